// ===== sv/rbma_pkg.sv =====
// ---------------------------------------------------------------------------
// rbma_pkg - moving average shared definitions
// Window size, sample/sum/count widths used by the ring and the divider.
// ---------------------------------------------------------------------------
`default_nettype none

package rbma_pkg;

	localparam int WINDOW      = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int SLOT_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int COUNT_BITS  = $clog2(WINDOW + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW);
	localparam int STEP_BITS   = $clog2(SUM_BITS);

endpackage

`default_nettype wire

// ===== sv/rbma_div.sv =====
// ---------------------------------------------------------------------------
// rbma_div - bit-serial signed divider
// Divides the signed window sum by the positive held count, one quotient
// bit per cycle (restoring, on magnitudes), truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module rbma_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [rbma_pkg::SUM_BITS-1:0]       dividend,
	input  wire logic [rbma_pkg::COUNT_BITS-1:0]     divisor,
	output logic                                     done,
	output logic signed [rbma_pkg::SAMPLE_BITS-1:0] quotient
);
	import rbma_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [SUM_BITS-1:0]   mag_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;

	logic [COUNT_BITS:0]   rem_sh;
	logic                  fits;
	logic [COUNT_BITS:0]   rem_diff;
	logic [SUM_BITS-1:0]   quo_signed;

	always_comb begin
		rem_sh   = {rem_q, mag_q[SUM_BITS-1]};
		fits     = rem_sh >= {1'b0, div_q};
		rem_diff = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_BITS'(1);
			if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_BITS-1];
			mag_q <= dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_BITS-2:0], 1'b0};
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			rem_q <= fits ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
		end
	end

	assign quo_signed = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;
	assign quotient   = quo_signed[SAMPLE_BITS-1:0];
	assign done       = done_q;

endmodule

`default_nettype wire

// ===== sv/ring_buffer_moving_average.sv =====
// ---------------------------------------------------------------------------
// ring_buffer_moving_average - simple moving average over a sample ring
// Keeps the last WINDOW samples in a ring memory plus a running sum, and
// gives the truncated mean of the held samples for every sample taken.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | sample (16b signed)
//  output   | out_valid/ out_ready | average (16b signed), held_count (5b)
//
//  Each item passes through these steps: the ring is read at the accepting
//  edge, the update state adds to the sum and writes the ring back, the
//  bit-serial divider works out SUM_BITS (20) quotient bits, and the output
//  register is loaded. A finished result waits in the output
//  register, so the next item is taken while it is still pending; only a
//  second result stalls in the divide state until the register frees up.
//  Reset clears the write slot, fill count and sum; the ring needs no
//  clearing since an entry read before the ring is full is never summed.
// ---------------------------------------------------------------------------
`default_nettype none

module ring_buffer_moving_average (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic signed [rbma_pkg::SAMPLE_BITS-1:0]  sample,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic signed [rbma_pkg::SAMPLE_BITS-1:0]       average,
	output logic [rbma_pkg::COUNT_BITS-1:0]               held_count
);
	import rbma_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV
	} state_t;

	state_t                  state_q;

	// ring storage, one write and one registered read port
	logic [SAMPLE_BITS-1:0]  ring_mem [WINDOW];
	logic [SAMPLE_BITS-1:0]  old_s1;
	logic [SAMPLE_BITS-1:0]  sample_s1;

	logic [SLOT_BITS-1:0]    slot_q;
	logic [COUNT_BITS-1:0]   fill_q;
	logic [SUM_BITS-1:0]     sum_q;

	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  average_q;
	logic [COUNT_BITS-1:0]   held_q;

	logic                    accept;
	logic                    ring_full;
	logic [SUM_BITS-1:0]     old_ext;
	logic [SUM_BITS-1:0]     new_ext;
	logic [SUM_BITS-1:0]     sum_nx;
	logic [COUNT_BITS-1:0]   fill_nx;
	logic                    div_start;
	logic                    div_done;
	logic signed [SAMPLE_BITS-1:0] div_quot;
	logic                    out_free;
	logic                    load_out;

	assign accept    = in_valid && in_ready;
	assign ring_full = fill_q == COUNT_BITS'(WINDOW);
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_DIV) && div_done && out_free;

	always_comb begin
		old_ext = {{(SUM_BITS-SAMPLE_BITS){old_s1[SAMPLE_BITS-1]}}, old_s1};
		new_ext = {{(SUM_BITS-SAMPLE_BITS){sample_s1[SAMPLE_BITS-1]}}, sample_s1};
		// full ring: oldest sample leaves the sum as the new one enters
		sum_nx  = sum_q - (ring_full ? old_ext : '0) + new_ext;
		fill_nx = ring_full ? fill_q : fill_q + COUNT_BITS'(1);
	end

	assign div_start = state_q == ST_UPD;

	// read the slot on accept, write the new sample back in the following update state
	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1    <= ring_mem[slot_q];
			sample_s1 <= sample;
		end
		if (state_q == ST_UPD) begin
			ring_mem[slot_q] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			average_q   <= '0;
			held_q      <= '0;
		end else begin
			// a new result may land in the same cycle the old one leaves
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q   <= sum_nx;
					fill_q  <= fill_nx;
					slot_q  <= (slot_q == SLOT_BITS'(WINDOW - 1)) ?
					           '0 : slot_q + SLOT_BITS'(1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (load_out) begin
						average_q   <= div_quot;
						held_q      <= fill_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	rbma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nx),
		.divisor  (fill_nx),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign in_ready   = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign average    = average_q;
	assign held_count = held_q;

endmodule

`default_nettype wire
